>>> hdl/battery_level_monitor_defines.svh
// Assertion macros used by the battery level monitor controller.
`ifndef BATTERY_LEVEL_MONITOR_DEFINES_SVH
`define BATTERY_LEVEL_MONITOR_DEFINES_SVH

// Combinational check, sampled on every clock outside reset.
`define BLM_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that holds in the cycle after the trigger.
`define BLM_ASSERT_NEXT(label, trig, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/blm_pkg.sv
// Package: types and constants of the battery level monitor.
`timescale 1ns / 1ps
package blm_pkg;

	localparam int SAMPLE_W            = 10;
	localparam int SUM_W               = 16;
	localparam int CNT_W               = 6;
	localparam int SAMPLES_PER_READING = 8;
	localparam int CODE_W              = 10;
	localparam int MV_W                = 16;
	localparam int PCT_W               = 14;
	localparam int CFG_IDX_W           = 2;
	localparam int PROD1_W             = 26;
	localparam int DVD_W               = 30;
	localparam int DVS_W               = 16;
	localparam int DIV_CNT_W           = 5;
	localparam int DIV_STEPS           = 30;

	localparam logic [CODE_W-1:0] ADC_MAX_CODE = 10'd1023;
	localparam logic [PCT_W-1:0]  PERCENT_FULL = 14'd10000;

	localparam logic [MV_W-1:0] FULL_SCALE_RST = 16'd5000;
	localparam logic [MV_W-1:0] EMPTY_RST      = 16'd3000;
	localparam logic [MV_W-1:0] FULL_RST       = 16'd4200;
	localparam logic [MV_W-1:0] DISCONNECT_RST = 16'd1000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FULL_SCALE = 2'd0,
		CFG_EMPTY      = 2'd1,
		CFG_FULL       = 2'd2,
		CFG_DISCONNECT = 2'd3
	} cfg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL1,
		S_FOLD,
		S_MV,
		S_MUL2,
		S_DIV_GO,
		S_DIV_WAIT,
		S_FIN
	} state_t;

	typedef struct packed {
		logic acc;
		logic mul1;
		logic fold;
		logic div_start;
		logic mv_load;
		logic mul2;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic last;
		logic span_zero;
		logic div_busy;
		logic div_done;
	} sts_t;

endpackage

>>> hdl/blm_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module blm_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [blm_pkg::DVD_W-1:0]    dividend,
	input  logic [blm_pkg::DVS_W-1:0]    divisor,
	output logic                         busy,
	output logic                         done,
	output logic [blm_pkg::DVD_W-1:0]    quotient
);

	logic                              busy_q;
	logic [blm_pkg::DIV_CNT_W-1:0]     cnt_q;
	logic [blm_pkg::DVD_W-1:0]         dvd_q;
	logic [blm_pkg::DVS_W-1:0]         dvs_q;
	logic [blm_pkg::DVS_W-1:0]         rem_q;
	logic [blm_pkg::DVS_W:0]           rem_sh;
	logic [blm_pkg::DVS_W:0]           rem_sub;
	logic                              ge;

	assign rem_sh  = {rem_q, dvd_q[blm_pkg::DVD_W-1]};
	assign ge      = rem_sh >= {1'b0, dvs_q};
	assign rem_sub = rem_sh - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= blm_pkg::DIV_CNT_W'(blm_pkg::DIV_STEPS - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[blm_pkg::DVD_W-2:0], ge};
			rem_q <= ge ? rem_sub[blm_pkg::DVS_W-1:0] : rem_sh[blm_pkg::DVS_W-1:0];
		end
	end

	assign busy     = busy_q;
	assign done     = busy_q && (cnt_q == '0);
	assign quotient = dvd_q;

endmodule

>>> hdl/blm_dp.sv
// Datapath: config registers, sample accumulator, scaling and percent math.
`timescale 1ns / 1ps
module blm_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [blm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [blm_pkg::MV_W-1:0]        cfg_data,
	input  logic [blm_pkg::SAMPLE_W-1:0]    adc_sample,
	input  blm_pkg::cmd_t                   cmd,
	output blm_pkg::sts_t                   sts,
	output logic [blm_pkg::MV_W-1:0]        voltage_mv,
	output logic [blm_pkg::PCT_W-1:0]       percent_centi,
	output logic                            connected,
	output logic                            calibration_bad
);

	logic [blm_pkg::MV_W-1:0]     full_scale_q, empty_q, full_q, disc_q;
	logic [blm_pkg::SUM_W-1:0]    sum_q;
	logic [blm_pkg::CNT_W-1:0]    count_q;
	logic [blm_pkg::CODE_W-1:0]   code_q;
	logic [blm_pkg::PROD1_W-1:0]  prod1_q;
	logic [blm_pkg::MV_W-1:0]     fold_a_q;
	logic [blm_pkg::MV_W:0]       fold_y_q;
	logic [blm_pkg::MV_W-1:0]     mv_q;
	logic [blm_pkg::DVD_W-1:0]    prod2_q;
	logic                         neg_q;

	logic [blm_pkg::SUM_W:0]      sum_ext;
	logic [blm_pkg::SUM_W-1:0]    sum_sat;
	logic [blm_pkg::SUM_W-1:0]    avg;
	logic [blm_pkg::CODE_W-1:0]   code_clamp;
	logic [blm_pkg::CODE_W:0]     fold_z;
	logic                         fold_c;
	logic [blm_pkg::MV_W-1:0]     mv_fold;
	logic [blm_pkg::MV_W:0]       diff, span, diff_mag, span_mag;
	logic                         span_zero;
	logic                         last;
	logic [blm_pkg::DVD_W-1:0]    quo;
	logic                         div_busy, div_done;
	logic [blm_pkg::PCT_W-1:0]    pct;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_scale_q <= blm_pkg::FULL_SCALE_RST;
			empty_q      <= blm_pkg::EMPTY_RST;
			full_q       <= blm_pkg::FULL_RST;
			disc_q       <= blm_pkg::DISCONNECT_RST;
		end else if (cfg_we) begin
			unique case (blm_pkg::cfg_idx_t'(cfg_index))
				blm_pkg::CFG_FULL_SCALE: full_scale_q <= cfg_data;
				blm_pkg::CFG_EMPTY:      empty_q      <= cfg_data;
				blm_pkg::CFG_FULL:       full_q       <= cfg_data;
				blm_pkg::CFG_DISCONNECT: disc_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	// accumulator, saturating
	assign sum_ext    = {1'b0, sum_q} + (blm_pkg::SUM_W+1)'(adc_sample);
	assign sum_sat    = sum_ext[blm_pkg::SUM_W] ? '1 : sum_ext[blm_pkg::SUM_W-1:0];
	assign avg        = sum_sat / blm_pkg::SUM_W'(blm_pkg::SAMPLES_PER_READING);
	assign code_clamp = (avg > blm_pkg::SUM_W'(blm_pkg::ADC_MAX_CODE)) ?
		blm_pkg::ADC_MAX_CODE : avg[blm_pkg::CODE_W-1:0];
	assign last       = count_q == blm_pkg::CNT_W'(blm_pkg::SAMPLES_PER_READING - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			count_q <= '0;
		end else if (cmd.acc) begin
			if (last) begin
				sum_q   <= '0;
				count_q <= '0;
			end else begin
				sum_q   <= sum_sat;
				count_q <= count_q + 1'b1;
			end
		end
	end

	// divide by 1023: x = 1023*hi + (hi + lo), folded twice
	assign fold_z  = (blm_pkg::CODE_W+1)'(fold_y_q[blm_pkg::MV_W:blm_pkg::CODE_W]) +
		{1'b0, fold_y_q[blm_pkg::CODE_W-1:0]};
	assign fold_c  = fold_z >= (blm_pkg::CODE_W+1)'(blm_pkg::ADC_MAX_CODE);
	assign mv_fold = fold_a_q + blm_pkg::MV_W'(fold_y_q[blm_pkg::MV_W:blm_pkg::CODE_W]) +
		blm_pkg::MV_W'(fold_c);

	// percent operands
	assign diff      = {1'b0, mv_q} - {1'b0, empty_q};
	assign span      = {1'b0, full_q} - {1'b0, empty_q};
	assign diff_mag  = diff[blm_pkg::MV_W] ? ('0 - diff) : diff;
	assign span_mag  = span[blm_pkg::MV_W] ? ('0 - span) : span;
	assign span_zero = full_q == empty_q;

	blm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (prod2_q),
		.divisor  (span_mag[blm_pkg::DVS_W-1:0]),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (quo)
	);

	always_ff @(posedge clk) begin
		if (cmd.acc && last) begin
			code_q <= code_clamp;
		end
		if (cmd.mul1) begin
			prod1_q <= blm_pkg::PROD1_W'(code_q) * blm_pkg::PROD1_W'(full_scale_q);
		end
		if (cmd.fold) begin
			fold_a_q <= prod1_q[blm_pkg::PROD1_W-1:blm_pkg::CODE_W];
			fold_y_q <= {1'b0, prod1_q[blm_pkg::PROD1_W-1:blm_pkg::CODE_W]} +
				(blm_pkg::MV_W+1)'(prod1_q[blm_pkg::CODE_W-1:0]);
		end
		if (cmd.mv_load) begin
			mv_q <= mv_fold;
		end
		if (cmd.mul2) begin
			prod2_q <= blm_pkg::DVD_W'(diff_mag[blm_pkg::MV_W-1:0]) *
				blm_pkg::DVD_W'(blm_pkg::PERCENT_FULL);
			neg_q   <= diff[blm_pkg::MV_W] ^ span[blm_pkg::MV_W];
		end
	end

	// negative quotient or zero span gives zero; quotient above full clamps to full
	always_comb begin
		if (span_zero || neg_q) begin
			pct = '0;
		end else if (quo > blm_pkg::DVD_W'(blm_pkg::PERCENT_FULL)) begin
			pct = blm_pkg::PERCENT_FULL;
		end else begin
			pct = quo[blm_pkg::PCT_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			voltage_mv      <= mv_q;
			percent_centi   <= pct;
			connected       <= mv_q >= disc_q;
			calibration_bad <= span_zero;
		end
	end

	assign sts.last      = last;
	assign sts.span_zero = span_zero;
	assign sts.div_busy  = div_busy;
	assign sts.div_done  = div_done;

endmodule

>>> hdl/blm_ctrl.sv
// Controller: sequences accumulation, scaling, division and result handoff.
`timescale 1ns / 1ps
`include "battery_level_monitor_defines.svh"
module blm_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  blm_pkg::sts_t  sts,
	output blm_pkg::cmd_t  cmd
);

	blm_pkg::state_t state_q, state_d;
	logic            out_valid_q;
	logic            out_free;

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= blm_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			blm_pkg::S_IDLE: begin
				if (in_valid && sts.last) state_d = blm_pkg::S_MUL1;
			end
			blm_pkg::S_MUL1:      state_d = blm_pkg::S_FOLD;
			blm_pkg::S_FOLD:      state_d = blm_pkg::S_MV;
			blm_pkg::S_MV:        state_d = blm_pkg::S_MUL2;
			blm_pkg::S_MUL2: begin
				state_d = sts.span_zero ? blm_pkg::S_FIN : blm_pkg::S_DIV_GO;
			end
			blm_pkg::S_DIV_GO:    state_d = blm_pkg::S_DIV_WAIT;
			blm_pkg::S_DIV_WAIT: begin
				if (sts.div_done) state_d = blm_pkg::S_FIN;
			end
			blm_pkg::S_FIN: begin
				if (out_free) state_d = blm_pkg::S_IDLE;
			end
			default:              state_d = blm_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			blm_pkg::S_IDLE: begin
				in_ready = 1'b1;
				cmd.acc  = in_valid;
			end
			blm_pkg::S_MUL1:   cmd.mul1 = 1'b1;
			blm_pkg::S_FOLD:   cmd.fold = 1'b1;
			blm_pkg::S_MV:     cmd.mv_load = 1'b1;
			blm_pkg::S_MUL2:   cmd.mul2 = 1'b1;
			blm_pkg::S_DIV_GO: cmd.div_start = 1'b1;
			blm_pkg::S_FIN:    cmd.out_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	`BLM_ASSERT(a_div_start_idle, !cmd.div_start || !sts.div_busy, "divider restarted while busy")
	`BLM_ASSERT_NEXT(a_last_starts, in_valid && in_ready && sts.last, state_q == blm_pkg::S_MUL1, "last item did not start a reading")
	`BLM_ASSERT(a_load_free, !cmd.out_load || !out_valid_q || out_ready, "result overwritten before taken")

endmodule

>>> hdl/battery_level_monitor.sv
// Top level: battery level monitor, averaging and state-of-charge reporting.
// Items are accepted one per cycle while accumulating; a block is 8 items.
// After the last item of a block the controller runs multiply, fold, millivolt load,
// second multiply and the 30-step percent division (skipped when full and empty levels
// are equal), then loads the result; no item is accepted until that load is done.
// Asynchronous active-low reset restores default levels and clears the sum.
`timescale 1ns / 1ps
module battery_level_monitor (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [blm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [blm_pkg::MV_W-1:0]        cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [blm_pkg::SAMPLE_W-1:0]    adc_sample,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [blm_pkg::MV_W-1:0]        voltage_mv,
	output logic [blm_pkg::PCT_W-1:0]       percent_centi,
	output logic                            connected,
	output logic                            calibration_bad
);

	blm_pkg::cmd_t cmd;
	blm_pkg::sts_t sts;

	blm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	blm_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.adc_sample      (adc_sample),
		.cmd             (cmd),
		.sts             (sts),
		.voltage_mv      (voltage_mv),
		.percent_centi   (percent_centi),
		.connected       (connected),
		.calibration_bad (calibration_bad)
	);

endmodule

>>> bench/tb_top.sv
// Testbench for the battery level monitor: directed table, then randomized phases
// with reconfiguration, checked against an internal predictor.
`timescale 1ns / 1ps
module tb_top;

	localparam int unsigned LIMIT = 600000;
	localparam int DRAIN_CYCLES = 80;
	localparam int DIR_ROWS = 24;
	localparam int ZSPAN_ROW = 16;

	typedef struct packed {
		logic [blm_pkg::MV_W-1:0]  mv;
		logic [blm_pkg::PCT_W-1:0] pct;
		logic                      conn;
		logic                      bad;
	} reading_t;

	typedef struct packed {
		logic [blm_pkg::SAMPLE_W-1:0] code;
		logic                         typed;
		reading_t                     want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [blm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [blm_pkg::MV_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [blm_pkg::SAMPLE_W-1:0] adc_sample = '0;
	logic out_valid;
	logic out_ready = 1'b1;
	logic [blm_pkg::MV_W-1:0] voltage_mv;
	logic [blm_pkg::PCT_W-1:0] percent_centi;
	logic connected;
	logic calibration_bad;

	battery_level_monitor dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.adc_sample(adc_sample),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.voltage_mv(voltage_mv),
		.percent_centi(percent_centi),
		.connected(connected),
		.calibration_bad(calibration_bad)
	);

	always #10 clk = ~clk;

	// predictor state
	logic [blm_pkg::MV_W-1:0] lvl_full_scale = blm_pkg::FULL_SCALE_RST;
	logic [blm_pkg::MV_W-1:0] lvl_empty = blm_pkg::EMPTY_RST;
	logic [blm_pkg::MV_W-1:0] lvl_full = blm_pkg::FULL_RST;
	logic [blm_pkg::MV_W-1:0] lvl_disconnect = blm_pkg::DISCONNECT_RST;
	logic [blm_pkg::SUM_W-1:0] acc_sum = '0;
	logic [blm_pkg::CNT_W-1:0] acc_count = '0;

	reading_t pending_readings[$];
	int mismatches = 0;
	int unsigned cycle_count = 0;
	int stall_max = 0;
	int stall_left = 0;
	int gap_max = 0;
	int burst_left = 0;
	int block_style = 0;
	int block_center = 0;

	dir_row_t dir_rows [0:DIR_ROWS-1] = '{
		'{10'h000, 1'b0, '{16'd0, 14'd0, 1'b0, 1'b0}},
		'{10'h000, 1'b0, '{16'd0, 14'd0, 1'b0, 1'b0}},
		'{10'h000, 1'b0, '{16'd0, 14'd0, 1'b0, 1'b0}},
		'{10'h000, 1'b0, '{16'd0, 14'd0, 1'b0, 1'b0}},
		'{10'h000, 1'b0, '{16'd0, 14'd0, 1'b0, 1'b0}},
		'{10'h000, 1'b0, '{16'd0, 14'd0, 1'b0, 1'b0}},
		'{10'h000, 1'b0, '{16'd0, 14'd0, 1'b0, 1'b0}},
		'{10'h000, 1'b1, '{16'd0, 14'd0, 1'b0, 1'b0}},
		'{10'h3FF, 1'b0, '{16'd0, 14'd0, 1'b0, 1'b0}},
		'{10'h3FF, 1'b0, '{16'd0, 14'd0, 1'b0, 1'b0}},
		'{10'h3FF, 1'b0, '{16'd0, 14'd0, 1'b0, 1'b0}},
		'{10'h3FF, 1'b0, '{16'd0, 14'd0, 1'b0, 1'b0}},
		'{10'h3FF, 1'b0, '{16'd0, 14'd0, 1'b0, 1'b0}},
		'{10'h3FF, 1'b0, '{16'd0, 14'd0, 1'b0, 1'b0}},
		'{10'h3FF, 1'b0, '{16'd0, 14'd0, 1'b0, 1'b0}},
		'{10'h3FF, 1'b1, '{16'd5000, 14'd10000, 1'b1, 1'b0}},
		// zero span: full level equals empty level
		'{10'h2AA, 1'b0, '{16'd0, 14'd0, 1'b0, 1'b0}},
		'{10'h155, 1'b0, '{16'd0, 14'd0, 1'b0, 1'b0}},
		'{10'h2AA, 1'b0, '{16'd0, 14'd0, 1'b0, 1'b0}},
		'{10'h155, 1'b0, '{16'd0, 14'd0, 1'b0, 1'b0}},
		'{10'h2AA, 1'b0, '{16'd0, 14'd0, 1'b0, 1'b0}},
		'{10'h155, 1'b0, '{16'd0, 14'd0, 1'b0, 1'b0}},
		'{10'h2AA, 1'b0, '{16'd0, 14'd0, 1'b0, 1'b0}},
		'{10'h155, 1'b0, '{16'd0, 14'd0, 1'b0, 1'b0}}
	};

	task automatic predict_sample(input logic [blm_pkg::SAMPLE_W-1:0] code_in,
			output bit emit, output reading_t r);
		int unsigned code;
		longint mv;
		longint span;
		longint pct;
		int unsigned total;
		total = acc_sum + code_in;
		acc_sum = (total > 65535) ? 16'hFFFF : total[blm_pkg::SUM_W-1:0];
		acc_count = acc_count + 1'b1;
		emit = 1'b0;
		r = '0;
		if (acc_count != 0 && acc_count < blm_pkg::SAMPLES_PER_READING)
			return;
		code = acc_sum / blm_pkg::SAMPLES_PER_READING;
		if (code > blm_pkg::ADC_MAX_CODE)
			code = blm_pkg::ADC_MAX_CODE;
		acc_sum = '0;
		acc_count = '0;
		mv = (longint'(code) * longint'(lvl_full_scale)) / longint'(blm_pkg::ADC_MAX_CODE);
		span = longint'(lvl_full) - longint'(lvl_empty);
		if (span == 0) begin
			pct = 0;
			r.bad = 1'b1;
		end else begin
			pct = ((mv - longint'(lvl_empty)) * longint'(blm_pkg::PERCENT_FULL)) / span;
			if (pct < 0)
				pct = 0;
			if (pct > longint'(blm_pkg::PERCENT_FULL))
				pct = longint'(blm_pkg::PERCENT_FULL);
		end
		r.mv = mv[blm_pkg::MV_W-1:0];
		r.pct = pct[blm_pkg::PCT_W-1:0];
		r.conn = (mv >= longint'(lvl_disconnect));
		emit = 1'b1;
	endtask

	task automatic report_mismatch(input string field, input int got, input int want);
		$display("MISMATCH %s: got %0d, expected %0d at cycle %0d", field, got, want,
			cycle_count);
		mismatches++;
	endtask

	task automatic send_item(input logic [blm_pkg::SAMPLE_W-1:0] code_in, input bit typed,
			input reading_t want);
		bit emit;
		reading_t r;
		in_valid <= 1'b1;
		adc_sample <= code_in;
		do @(posedge clk); while (!in_ready);
		predict_sample(code_in, emit, r);
		if (emit)
			pending_readings.push_back(typed ? want : r);
	endtask

	task automatic idle_cycles(input int n);
		in_valid <= 1'b0;
		adc_sample <= blm_pkg::SAMPLE_W'($urandom);
		repeat (n) @(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_readings.size() != 0);
	endtask

	task automatic write_reg(input blm_pkg::cfg_idx_t idx,
			input logic [blm_pkg::MV_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		case (idx)
			blm_pkg::CFG_FULL_SCALE: lvl_full_scale = v;
			blm_pkg::CFG_EMPTY:      lvl_empty = v;
			blm_pkg::CFG_FULL:       lvl_full = v;
			blm_pkg::CFG_DISCONNECT: lvl_disconnect = v;
			default: ;
		endcase
	endtask

	task automatic set_levels(input logic [blm_pkg::MV_W-1:0] fs,
			input logic [blm_pkg::MV_W-1:0] e, input logic [blm_pkg::MV_W-1:0] f,
			input logic [blm_pkg::MV_W-1:0] d);
		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		write_reg(blm_pkg::CFG_FULL_SCALE, fs);
		write_reg(blm_pkg::CFG_EMPTY, e);
		write_reg(blm_pkg::CFG_FULL, f);
		write_reg(blm_pkg::CFG_DISCONNECT, d);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [blm_pkg::SAMPLE_W-1:0] pick_sample();
		int v;
		if (acc_count == 0) begin
			block_style = $urandom_range(0, 3);
			block_center = $urandom_range(0, 1023);
		end
		case (block_style)
			0: v = $urandom_range(0, 1023);
			1: v = block_center;
			2: v = block_center + $urandom_range(0, 6) - 3;
			default: v = $urandom_range(0, 1) ? 1023 : 0;
		endcase
		if (v < 0)
			v = 0;
		if (v > 1023)
			v = 1023;
		return v[blm_pkg::SAMPLE_W-1:0];
	endfunction

	task automatic run_phase(input int n, input int gaps, input int stalls);
		int pause_at;
		gap_max = gaps;
		stall_max = stalls;
		burst_left = $urandom_range(1, 24);
		pause_at = $urandom_range(n / 4, 3 * n / 4);
		for (int k = 0; k < n; k++) begin
			if (k == pause_at)
				drain();
			if (gap_max != 0 && burst_left == 0) begin
				idle_cycles($urandom_range(1, gap_max));
				burst_left = $urandom_range(1, 24);
			end
			send_item(pick_sample(), 1'b0, '0);
			burst_left--;
		end
	endtask

	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else if (stall_max != 0 && $urandom_range(0, 3) == 0) begin
			stall_left <= $urandom_range(1, stall_max);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		reading_t want;
		cycle_count <= cycle_count + 1;
		if (arst_n && out_valid && out_ready) begin
			if (pending_readings.size() == 0) begin
				report_mismatch("unexpected reading, voltage_mv", voltage_mv, -1);
			end else begin
				want = pending_readings.pop_front();
				if (voltage_mv !== want.mv)
					report_mismatch("voltage_mv", voltage_mv, want.mv);
				if (percent_centi !== want.pct)
					report_mismatch("percent_centi", percent_centi, want.pct);
				if (connected !== want.conn)
					report_mismatch("connected", connected, want.conn);
				if (calibration_bad !== want.bad)
					report_mismatch("calibration_bad", calibration_bad, want.bad);
			end
		end
	end

	initial begin
		wait (cycle_count >= LIMIT);
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_ROWS; i++) begin
			if (i == ZSPAN_ROW)
				set_levels(blm_pkg::FULL_SCALE_RST, blm_pkg::EMPTY_RST, blm_pkg::EMPTY_RST,
					blm_pkg::DISCONNECT_RST);
			send_item(dir_rows[i].code, dir_rows[i].typed, dir_rows[i].want);
		end

		set_levels(blm_pkg::FULL_SCALE_RST, blm_pkg::EMPTY_RST, blm_pkg::FULL_RST,
			blm_pkg::DISCONNECT_RST);
		run_phase(180 + $urandom_range(0, 7), 0, 0);
		set_levels(16'd0, 16'd0, 16'd0, 16'd0);
		run_phase(180 + $urandom_range(0, 7), 8, 0);
		set_levels(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		run_phase(180 + $urandom_range(0, 7), 0, 12);
		set_levels(16'hFFFF, 16'd0, 16'hFFFF, 16'd0);
		run_phase(180 + $urandom_range(0, 7), 10, 30);
		// inverted span
		set_levels(16'd5000, 16'd4200, 16'd3000, 16'd2500);
		run_phase(180 + $urandom_range(0, 7), 4, 6);
		set_levels(16'd5000, 16'd2000, 16'd2001, 16'd4999);
		run_phase(180 + $urandom_range(0, 7), 3, 3);
		for (int p = 0; p < 4; p++) begin
			set_levels(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 8000)),
				16'($urandom_range(0, 8000)), 16'($urandom_range(0, 8000)));
			run_phase(180 + $urandom_range(0, 7), $urandom_range(0, 10),
				$urandom_range(0, 20));
		end

		drain();
		stall_max = 0;
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_readings.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
